// ===== rtl/core/vtt_pkg.sv =====
// ----------------------------------------------------------------------------
// vtt_pkg
// Types, code constants and the pair decode shared by the text transcoder.
// ----------------------------------------------------------------------------
package vtt_pkg;

	localparam int unsigned ByteW = 8;

	localparam logic [ByteW-1:0] ChA      = 8'h61;
	localparam logic [ByteW-1:0] ChE      = 8'h65;
	localparam logic [ByteW-1:0] ChI      = 8'h69;
	localparam logic [ByteW-1:0] ChO      = 8'h6F;
	localparam logic [ByteW-1:0] ChU      = 8'h75;
	localparam logic [ByteW-1:0] ChY      = 8'h79;
	localparam logic [ByteW-1:0] ChDLo    = 8'h64;
	localparam logic [ByteW-1:0] ChDUp    = 8'h44;
	localparam logic [ByteW-1:0] Dig1     = 8'h31;
	localparam logic [ByteW-1:0] Dig5     = 8'h35;
	localparam logic [ByteW-1:0] Dig6     = 8'h36;
	localparam logic [ByteW-1:0] Dig7     = 8'h37;
	localparam logic [ByteW-1:0] Dig8     = 8'h38;
	localparam logic [ByteW-1:0] Dig9     = 8'h39;

	localparam logic [ByteW-1:0] BaseA8   = 8'd128;
	localparam logic [ByteW-1:0] BaseA6   = 8'd134;
	localparam logic [ByteW-1:0] BaseE6   = 8'd140;
	localparam logic [ByteW-1:0] BaseO7   = 8'd146;
	localparam logic [ByteW-1:0] BaseO6   = 8'd152;
	localparam logic [ByteW-1:0] BaseU7   = 8'd158;
	localparam logic [ByteW-1:0] CodeDLo  = 8'd249;
	localparam logic [ByteW-1:0] CodeDUp  = 8'd250;

	localparam logic [ByteW-1:0] TONE_TAB [6][5] = '{
		'{8'd164, 8'd165, 8'd166, 8'd167, 8'd168},
		'{8'd169, 8'd170, 8'd171, 8'd172, 8'd173},
		'{8'd174, 8'd175, 8'd181, 8'd182, 8'd183},
		'{8'd184, 8'd190, 8'd198, 8'd199, 8'd208},
		'{8'd210, 8'd211, 8'd212, 8'd213, 8'd214},
		'{8'd215, 8'd216, 8'd221, 8'd222, 8'd248}
	};

	typedef struct packed {
		logic [ByteW-1:0] code;
		logic             last;
	} res_t;

	typedef struct packed {
		logic v0;
		res_t r0;
		logic v1;
		res_t r1;
	} step_t;

	typedef struct packed {
		logic             hit;
		logic [ByteW-1:0] code;
	} merge_t;

	function automatic logic is_base(input logic [ByteW-1:0] v);
		return v == BaseA8 || v == BaseA6 || v == BaseE6 ||
			v == BaseO7 || v == BaseO6 || v == BaseU7;
	endfunction

	function automatic merge_t merge_pair(input logic [ByteW-1:0] first,
			input logic [ByteW-1:0] second);
		merge_t     m;
		logic       digit;
		logic       vowel;
		logic [2:0] vi;
		logic [2:0] ti;
		digit = second >= Dig1 && second <= Dig5;
		ti    = second[2:0] - 3'd1;
		vowel = 1'b1;
		vi    = 3'd0;
		unique case (first)
			ChA: vi = 3'd0;
			ChE: vi = 3'd1;
			ChI: vi = 3'd2;
			ChO: vi = 3'd3;
			ChU: vi = 3'd4;
			ChY: vi = 3'd5;
			default: vowel = 1'b0;
		endcase
		m.hit  = 1'b1;
		m.code = '0;
		priority if (first == ChA && second == Dig8) m.code = BaseA8;
		else if (first == ChA && second == Dig6) m.code = BaseA6;
		else if (first == ChE && second == Dig6) m.code = BaseE6;
		else if (first == ChO && second == Dig7) m.code = BaseO7;
		else if (first == ChO && second == Dig6) m.code = BaseO6;
		else if (first == ChU && second == Dig7) m.code = BaseU7;
		else if (is_base(first) && digit) m.code = first + {5'd0, second[2:0]};
		else if (vowel && digit) m.code = TONE_TAB[vi][ti];
		else if (first == ChDLo && second == Dig9) m.code = CodeDLo;
		else if (first == ChDUp && second == Dig9) m.code = CodeDUp;
		else m.hit = 1'b0;
		return m;
	endfunction

endpackage

// ===== rtl/core/vtt_in_if.sv =====
// ----------------------------------------------------------------------------
// vtt_in_if
// Input channel of the text transcoder: one text byte per item.
// ----------------------------------------------------------------------------
interface vtt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/vtt_out_if.sv =====
// ----------------------------------------------------------------------------
// vtt_out_if
// Output channel of the text transcoder: one transcoded byte per item.
// ----------------------------------------------------------------------------
interface vtt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/vni_text_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// vni_text_transcoder_unit
// Streaming decoder of letter-plus-digit sequences into code-page bytes.
//
// rx takes one text byte per item with in_last marking the end of a string;
// tx gives one transcoded byte per item with out_last on the final byte.
// Both are valid/ready channels; an item moves when valid and ready are high.
// A byte is registered, then decoded against the held lookahead byte; a
// released byte and, on in_last, the flushed held byte go to the output
// register. One byte is taken per cycle while tx accepts; an item that
// yields two results holds the input while the spill stage drains.
// The lookahead byte holds results back: a byte leaves only when the next
// byte fails to pair with it, or at in_last.
// Reset clears the held byte and empties the input and output registers.
// When tx stalls, nothing is consumed and rx.ready drops once a byte waits.
// ----------------------------------------------------------------------------
module vni_text_transcoder_unit (
	input  logic      clk,
	input  logic      arst_n,
	vtt_in_if.sink    rx,
	vtt_out_if.source tx
);
	import vtt_pkg::*;

	logic  pend;
	logic  take;
	logic  consume;
	step_t step;

	assign consume = pend && take;

	vtt_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.consume (consume),
		.pend    (pend),
		.step    (step)
	);

	vtt_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (consume),
		.step   (step),
		.take   (take),
		.tx     (tx)
	);

endmodule

// ===== rtl/core/vtt_merge.sv =====
// ----------------------------------------------------------------------------
// vtt_merge
// Input register, lookahead byte and pair decode; yields up to two results.
// ----------------------------------------------------------------------------
module vtt_merge (
	input  logic          clk,
	input  logic          arst_n,
	vtt_in_if.sink        rx,
	input  logic          consume,
	output logic          pend,
	output vtt_pkg::step_t step
);
	import vtt_pkg::*;

	logic             v_s1;
	logic [ByteW-1:0] b_s1;
	logic             last_s1;
	logic             held_v_q;
	logic [ByteW-1:0] held_b_q;
	merge_t           m;
	logic             rel;
	logic [ByteW-1:0] nb;
	res_t             r_rel;
	res_t             r_fl;

	assign pend     = v_s1;
	assign rx.ready = !v_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			b_s1    <= rx.in_byte;
			last_s1 <= rx.in_last;
		end
	end

	always_comb begin
		m     = merge_pair(held_b_q, b_s1);
		rel   = held_v_q && !m.hit;
		nb    = (held_v_q && m.hit) ? m.code : b_s1;
		r_rel = '{code: held_b_q, last: 1'b0};
		r_fl  = '{code: nb, last: 1'b1};
		if (rel) begin
			step = '{v0: 1'b1, r0: r_rel, v1: last_s1, r1: r_fl};
		end else begin
			step = '{v0: last_s1, r0: r_fl, v1: 1'b0, r1: r_fl};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
			held_b_q <= '0;
		end else if (consume) begin
			held_v_q <= !last_s1;
			held_b_q <= last_s1 ? '0 : nb;
		end
	end

endmodule

// ===== rtl/core/vtt_out_buf.sv =====
// ----------------------------------------------------------------------------
// vtt_out_buf
// Output register with a spill stage for the second result of an item.
// ----------------------------------------------------------------------------
module vtt_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vtt_pkg::step_t step,
	output logic           take,
	vtt_out_if.source      tx
);
	import vtt_pkg::*;

	logic out_v_q;
	res_t out_q;
	logic spill_v_q;
	res_t spill_q;

	assign take        = !spill_v_q && (!out_v_q || tx.ready);
	assign tx.valid    = out_v_q;
	assign tx.out_byte = out_q.code;
	assign tx.out_last = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			spill_v_q <= 1'b0;
		end else if (spill_v_q) begin
			if (tx.ready) begin
				spill_v_q <= 1'b0;
			end
		end else if (push) begin
			out_v_q   <= step.v0;
			spill_v_q <= step.v1;
		end else if (out_v_q && tx.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (spill_v_q) begin
			if (tx.ready) begin
				out_q <= spill_q;
			end
		end else if (push) begin
			out_q   <= step.r0;
			spill_q <= step.r1;
		end
	end

endmodule

// ===== dv/tb_vni_text_transcoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vni_text_transcoder_unit
// Self-checking bench for the streaming letter-plus-digit transcoder.
//
// A driver feeds text bytes from a queue over the rx channel and, for every
// accepted byte, a software copy of the lookahead decoder works out the bytes
// that must leave on tx. A monitor compares each tx item with the oldest
// outstanding prediction. Directed strings hit every pair kind, raw base
// bytes, zero and top bytes and lone last bytes. Random text then mixes
// well-formed VNI words with noise, under three idling regimes and one long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_vni_text_transcoder_unit;

	import vtt_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} char_t;

	localparam int unsigned NumRandom = 2000;
	localparam int unsigned HoldOffCycles = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       drv_valid = 1'b0;
	logic [7:0] drv_byte = '0;
	logic       drv_last = 1'b0;
	logic       rdy_r = 1'b0;
	logic       hold_off = 1'b0;

	vtt_in_if rx_if ();
	vtt_out_if tx_if ();

	assign rx_if.valid   = drv_valid;
	assign rx_if.in_byte = drv_byte;
	assign rx_if.in_last = drv_last;
	assign tx_if.ready   = rdy_r;

	vni_text_transcoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	char_t char_q [$];
	res_t  decoded_q [$];

	logic       la_valid = 1'b0;
	logic [7:0] la_byte = '0;

	int n_total = 0;
	int sent_cnt = 0;
	int got_cnt = 0;
	int merge_cnt = 0;
	int err_cnt = 0;
	bit held_off_done = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int idle_phase();
		if (sent_cnt * 3 < n_total)
			return 0;
		if (sent_cnt * 3 < 2 * n_total)
			return 1;
		return 2;
	endfunction

	function automatic bit send_idle();
		case (idle_phase())
			0: return $urandom_range(99) < 36;
			1: return $urandom_range(99) < 46;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit recv_idle();
		case (idle_phase())
			0: return $urandom_range(99) < 46;
			1: return $urandom_range(99) < 36;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit pair_code(input logic [7:0] first, input logic [7:0] second,
			output logic [7:0] code);
		int  vi;
		bit  tone_digit;
		tone_digit = second >= "1" && second <= "5";
		code = '0;
		case ({first, second})
			{"a", "8"}: code = BaseA8;
			{"a", "6"}: code = BaseA6;
			{"e", "6"}: code = BaseE6;
			{"o", "7"}: code = BaseO7;
			{"o", "6"}: code = BaseO6;
			{"u", "7"}: code = BaseU7;
			default: ;
		endcase
		if (code != '0)
			return 1'b1;
		if ((first == BaseA8 || first == BaseA6 || first == BaseE6 ||
				first == BaseO7 || first == BaseO6 || first == BaseU7) && tone_digit) begin
			code = first + (second - "0");
			return 1'b1;
		end
		case (first)
			"a": vi = 0;
			"e": vi = 1;
			"i": vi = 2;
			"o": vi = 3;
			"u": vi = 4;
			"y": vi = 5;
			default: vi = -1;
		endcase
		if (vi >= 0 && tone_digit) begin
			code = TONE_TAB[vi][second - "1"];
			return 1'b1;
		end
		if (second == "9" && first == "d") begin
			code = CodeDLo;
			return 1'b1;
		end
		if (second == "9" && first == "D") begin
			code = CodeDUp;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic predict_char(input logic [7:0] b, input logic last);
		logic [7:0] code;
		if (la_valid) begin
			if (pair_code(la_byte, b, code)) begin
				la_byte = code;
				merge_cnt++;
			end else begin
				decoded_q.push_back('{code: la_byte, last: 1'b0});
				la_byte = b;
			end
		end else begin
			la_byte  = b;
			la_valid = 1'b1;
		end
		if (last) begin
			decoded_q.push_back('{code: la_byte, last: 1'b1});
			la_valid = 1'b0;
			la_byte  = '0;
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		char_q.push_back('{b: b, last: last});
	endtask

	task automatic push_str(input string s, input logic last);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], last && i == s.len() - 1);
	endtask

	// one random token of VNI text
	task automatic push_token();
		string base_l;
		string base_d;
		string vowels;
		int    k;
		base_l = "aaeoou";
		base_d = "866767";
		vowels = "aeiouy";
		k = $urandom_range(5);
		case ($urandom_range(7))
			0: begin
				push_byte(base_l[k], 1'b0);
				push_byte(base_d[k], 1'b0);
			end
			1: begin
				push_byte(base_l[k], 1'b0);
				push_byte(base_d[k], 1'b0);
				push_byte(8'("0") + 8'($urandom_range(1, 5)), 1'b0);
			end
			2: begin
				push_byte(k == 0 ? BaseA8 : k == 1 ? BaseA6 : k == 2 ? BaseE6 :
					k == 3 ? BaseO7 : k == 4 ? BaseO6 : BaseU7, 1'b0);
				push_byte(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
			end
			3, 4: begin
				push_byte(vowels[k], 1'b0);
				push_byte(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
			end
			5: begin
				push_byte($urandom_range(1) ? "d" : "D", 1'b0);
				push_byte($urandom_range(3) ? "9" : 8'("0") + 8'($urandom_range(9)), 1'b0);
			end
			6: push_byte(8'("a") + 8'($urandom_range(25)), 1'b0);
			default: push_byte(8'("0") + 8'($urandom_range(9)), 1'b0);
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_p
		char_t nxt;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_byte  <= '0;
			drv_last  <= 1'b0;
		end else begin
			if (drv_valid && rx_if.ready) begin
				predict_char(drv_byte, drv_last);
				sent_cnt++;
			end
			if (!drv_valid || rx_if.ready) begin
				if (char_q.size() > 0 && !send_idle()) begin
					nxt = char_q.pop_front();
					drv_valid <= 1'b1;
					drv_byte  <= nxt.b;
					drv_last  <= nxt.last;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor_p
		res_t want;
		if (!arst_n) begin
			rdy_r <= 1'b0;
		end else begin
			if (tx_if.valid && tx_if.ready) begin
				got_cnt++;
				if (decoded_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("ERROR: unexpected item byte=%0d last=%0b",
							tx_if.out_byte, tx_if.out_last);
				end else begin
					want = decoded_q.pop_front();
					if (tx_if.out_byte !== want.code || tx_if.out_last !== want.last) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("ERROR: item %0d expected byte=%0d last=%0b got byte=%0d last=%0b",
								got_cnt, want.code, want.last, tx_if.out_byte, tx_if.out_last);
					end
				end
			end
			rdy_r <= !hold_off && !recv_idle();
		end
	end

	// long receiver hold-off while the sender keeps offering items
	initial begin : hold_off_p
		while (n_total == 0 || sent_cnt < (2 * n_total) / 3 + 50)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HoldOffCycles) @(posedge clk);
		hold_off <= 1'b0;
		held_off_done = 1'b1;
	end

	initial begin : watchdog_p
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : main_p
		int n_rand;
		push_byte(8'h00, 1'b1);
		push_byte("a", 1'b1);
		push_str("a81", 1'b1);
		push_str("e65o7", 1'b1);
		push_str("o6u7y5", 1'b1);
		push_str("i3d9D9", 1'b1);
		push_byte(BaseU7, 1'b0);
		push_byte("3", 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		push_str("a12a9", 1'b1);
		n_rand = 0;
		while (n_rand < NumRandom) begin
			int before_n;
			before_n = char_q.size();
			if ($urandom_range(99) < 75) begin
				repeat ($urandom_range(1, 6)) push_token();
			end else begin
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)), 1'b0);
			end
			if ($urandom_range(99) < 70)
				char_q[char_q.size() - 1].last = 1'b1;
			n_rand += char_q.size() - before_n;
		end
		char_q[char_q.size() - 1].last = 1'b1;
		n_total = char_q.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (char_q.size() > 0 || drv_valid)
			@(posedge clk);
		while (decoded_q.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run: %0d bytes sent, %0d bytes checked, %0d pair merges",
			sent_cnt, got_cnt, merge_cnt);
		$display("Idling regimes: sender-heavy, receiver-heavy, none; hold-off %0s",
			held_off_done ? "done" : "not reached");
		if (err_cnt == 0 && decoded_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("Mismatches: %0d, outstanding: %0d", err_cnt, decoded_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
